// ----- rtl/core/bms_pkg.sv -----
// Shared types and constants for the buzzer melody sequencer.
// Field widths, operation and status codes, note record layout.
// No dependencies.
`timescale 1ns / 1ps

package bms_pkg;

   // Field widths of the request and response transactions.
   localparam int MODE_W   = 2;
   localparam int TUNE_W   = 4;
   localparam int SLOT_W   = 4;
   localparam int PERIOD_W = 16;
   localparam int DUR_W    = 16;
   localparam int STATUS_W = 2;

   // Default table geometry.
   localparam int NUM_TUNES_DEF      = 10;
   localparam int NOTES_PER_TUNE_DEF = 16;

   // Request operation codes.
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK  = 2'd0,
      MODE_PLAY  = 2'd1,
      MODE_WRITE = 2'd2
   } mode_type;

   // Play request status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_BUSY      = 2'd2
   } status_type;

   // One note as held in the note table.
   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [DUR_W-1:0]    duration;
   } note_type;

endpackage

// ----- rtl/core/bms_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents on a same-address write; no dependencies.
`timescale 1ns / 1ps

module bms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 160,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/buzzer_melody_sequencer.sv -----
// Buzzer melody sequencer: note table, tune playback control and tone outputs.
// Uses bms_pkg for codes and widths and bms_ram for the note table.
`timescale 1ns / 1ps

// The block takes one transaction per clock cycle when nothing stalls and
// returns exactly one response per transaction; each one passes through the
// input register and then the output register on its way out. The note
// table is a RAM with a registered read port; the note that the next tick may
// need (slot 0 of an armed tune, or the slot after the current one) is read
// ahead every cycle from the updated playback state, with a bypass for a
// write to that same note, so ticks never wait on the RAM. Each table entry
// has a valid bit that reset clears, so the table reads as all zero right
// after reset with no clearing pass. The mute code register is always ready
// and should be written only while the block is idle.
module buzzer_melody_sequencer #(
   parameter int NUM_TUNES      = bms_pkg::NUM_TUNES_DEF,
   parameter int NOTES_PER_TUNE = bms_pkg::NOTES_PER_TUNE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bms_pkg::MODE_W-1:0]    req_mode,
   input  logic [bms_pkg::TUNE_W-1:0]    req_tune_index,
   input  logic [bms_pkg::SLOT_W-1:0]    req_note_slot,
   input  logic [bms_pkg::PERIOD_W-1:0]  req_note_period,
   input  logic [bms_pkg::DUR_W-1:0]     req_note_duration,
   input  logic                          req_last_note,
   // Response channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bms_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_tone_on,
   output logic [bms_pkg::PERIOD_W-1:0]  rsp_tone_period,
   output logic                          rsp_playing,
   // Configuration write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bms_pkg::PERIOD_W-1:0]  csr_mute_code
);

   import bms_pkg::*;

   localparam int STORE_DEPTH = NUM_TUNES * NOTES_PER_TUNE;
   localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int TIW = (NUM_TUNES > 1) ? $clog2(NUM_TUNES) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(NOTES_PER_TUNE - 1);
   localparam logic [TUNE_W:0]   TUNE_LIMIT  = (TUNE_W + 1)'(NUM_TUNES);
   localparam logic [SLOT_W:0]   SLOT_LIMIT  = (SLOT_W + 1)'(NOTES_PER_TUNE);

   // Flat table address of a tune and slot.
   function automatic logic [AW-1:0] note_addr(input logic [TUNE_W-1:0] t,
                                               input logic [SLOT_W-1:0] s);
      logic [AW-1:0] base;
      base      = AW'(AW'(t) * AW'(NOTES_PER_TUNE));
      note_addr = base + AW'(s);
   endfunction

   // Input register.
   logic                in_valid_ff;
   logic [MODE_W-1:0]   in_mode_ff;
   logic [TUNE_W-1:0]   in_tune_ff;
   logic [SLOT_W-1:0]   in_slot_ff;
   logic [PERIOD_W-1:0] in_period_ff;
   logic [DUR_W-1:0]    in_duration_ff;
   logic                in_last_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_tone_on_ff;
   logic [PERIOD_W-1:0] rsp_tone_period_ff;
   logic                rsp_playing_ff;

   // Configuration and playback state.
   logic [PERIOD_W-1:0] mute_code_ff;
   logic [TUNE_W-1:0]   cur_tune_ff, cur_tune_in;
   logic [SLOT_W-1:0]   cur_slot_ff, cur_slot_in;
   logic [DUR_W-1:0]    remaining_ff, remaining_in;
   logic                start_pending_ff, start_pending_in;
   logic                is_playing_ff, is_playing_in;
   logic                tone_enable_ff, tone_enable_in;
   logic [PERIOD_W-1:0] tone_reload_ff, tone_reload_in;
   logic [NUM_TUNES-1:0] first_nz_ff, first_nz_in;
   logic [SLOT_W-1:0]   last_slot_ff [NUM_TUNES];
   logic [SLOT_W-1:0]   last_slot_in [NUM_TUNES];
   logic [STORE_DEPTH-1:0] note_valid_ff;

   // Note table read-ahead.
   logic                rd_valid_ff;
   logic                byp_ff;
   note_type            byp_data_ff;
   note_type            ram_q;
   note_type            note_cur;
   logic [AW-1:0]       rd_addr;
   logic [TUNE_W-1:0]   rd_tune;
   logic [SLOT_W-1:0]   rd_slot_base;
   logic [SLOT_W-1:0]   rd_slot;
   logic                rd_pending;

   // Per-transaction control.
   logic                out_free;
   logic                fire;
   logic                tune_ok;
   logic                slot_ok;
   logic                wr_en;
   logic                ram_wr_en;
   logic [AW-1:0]       wr_addr;
   note_type            wr_data;
   status_type          status_in;
   logic [SLOT_W-1:0]   last_raw;
   logic [SLOT_W-1:0]   last_lim;

   // Handshakes: output register frees up when empty or being taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !fire;
   assign csr_ready = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= (req_valid && !req_stall) || (in_valid_ff && !fire);
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_mode_ff     <= req_mode;
         in_tune_ff     <= req_tune_index;
         in_slot_ff     <= req_note_slot;
         in_period_ff   <= req_note_period;
         in_duration_ff <= req_note_duration;
         in_last_ff     <= req_last_note;
      end
   end

   // Mute code register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mute_code_ff <= '0;
      end else if (csr_valid) begin
         mute_code_ff <= csr_mute_code;
      end
   end

   // Note seen by a tick this cycle: bypass, then valid table entry, else zero.
   always_comb begin
      if (byp_ff) begin
         note_cur = byp_data_ff;
      end else if (rd_valid_ff) begin
         note_cur = ram_q;
      end else begin
         note_cur = '0;
      end
   end

   assign tune_ok  = {1'b0, in_tune_ff} < TUNE_LIMIT;
   assign slot_ok  = {1'b0, in_slot_ff} < SLOT_LIMIT;
   assign wr_addr  = note_addr(in_tune_ff, in_slot_ff);
   assign wr_data  = '{period: in_period_ff, duration: in_duration_ff};
   assign last_raw = last_slot_ff[cur_tune_ff[TIW-1:0]];
   assign last_lim = (last_raw > LAST_SLOT) ? LAST_SLOT : last_raw;

   // Transaction processing.
   always_comb begin
      cur_tune_in      = cur_tune_ff;
      cur_slot_in      = cur_slot_ff;
      remaining_in     = remaining_ff;
      start_pending_in = start_pending_ff;
      is_playing_in    = is_playing_ff;
      tone_enable_in   = tone_enable_ff;
      tone_reload_in   = tone_reload_ff;
      first_nz_in      = first_nz_ff;
      last_slot_in     = last_slot_ff;
      status_in        = STATUS_OK;
      wr_en            = 1'b0;
      if (fire) begin
         case (in_mode_ff)
            MODE_TICK: begin
               if (start_pending_ff) begin
                  // Start the armed tune on its first note.
                  start_pending_in = 1'b0;
                  is_playing_in    = 1'b1;
                  cur_slot_in      = '0;
                  remaining_in     = note_cur.duration;
                  if (note_cur.period != mute_code_ff) begin
                     tone_reload_in = note_cur.period;
                     tone_enable_in = 1'b1;
                  end
               end else if (is_playing_ff) begin
                  if (remaining_ff != '0) begin
                     remaining_in = remaining_ff - DUR_W'(1);
                  end else if (cur_slot_ff < last_lim) begin
                     // Move on to the next note.
                     cur_slot_in  = cur_slot_ff + SLOT_W'(1);
                     remaining_in = note_cur.duration;
                     if (note_cur.period == mute_code_ff) begin
                        tone_enable_in = 1'b0;
                     end else begin
                        tone_reload_in = note_cur.period;
                        tone_enable_in = 1'b1;
                     end
                  end else begin
                     // Past the last note: stop with the tone off.
                     is_playing_in  = 1'b0;
                     tone_enable_in = 1'b0;
                  end
               end
            end
            MODE_PLAY: begin
               if (!tune_ok) begin
                  status_in = STATUS_BAD_INDEX;
               end else if (is_playing_ff && (in_tune_ff == cur_tune_ff)) begin
                  status_in = STATUS_BUSY;
               end else begin
                  // Stop the current tune; arm the new one unless it is empty.
                  is_playing_in = 1'b0;
                  if (first_nz_ff[in_tune_ff[TIW-1:0]]) begin
                     cur_tune_in      = in_tune_ff;
                     start_pending_in = 1'b1;
                  end
               end
            end
            MODE_WRITE: begin
               if (tune_ok && slot_ok) begin
                  wr_en = 1'b1;
                  if (in_slot_ff == '0) begin
                     first_nz_in[in_tune_ff[TIW-1:0]] = (in_period_ff != '0);
                  end
                  if (in_last_ff) begin
                     last_slot_in[in_tune_ff[TIW-1:0]] = in_slot_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Read-ahead address, taken from the state that the next edge loads.
   always_comb begin
      rd_tune      = reset ? '0 : cur_tune_in;
      rd_pending   = reset ? 1'b0 : start_pending_in;
      rd_slot_base = reset ? '0 : cur_slot_in;
      rd_slot      = rd_pending ? '0 : rd_slot_base + SLOT_W'(1);
      if ({1'b0, rd_slot} >= SLOT_LIMIT) begin
         rd_slot = LAST_SLOT;
      end
      rd_addr = note_addr(rd_tune, rd_slot);
   end

   assign ram_wr_en = wr_en && !reset;

   bms_ram #(
      .WIDTH ($bits(note_type)),
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_note_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Entry valid bits and read-ahead bypass.
   always_ff @(posedge clock) begin
      if (reset) begin
         note_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
         byp_ff        <= 1'b0;
      end else begin
         if (ram_wr_en) begin
            note_valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= note_valid_ff[rd_addr];
         byp_ff      <= ram_wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= wr_data;
   end

   // Playback state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_tune_ff      <= '0;
         cur_slot_ff      <= '0;
         remaining_ff     <= '0;
         start_pending_ff <= 1'b0;
         is_playing_ff    <= 1'b0;
         tone_enable_ff   <= 1'b0;
         tone_reload_ff   <= '0;
         first_nz_ff      <= '0;
         last_slot_ff     <= '{default: '0};
      end else begin
         cur_tune_ff      <= cur_tune_in;
         cur_slot_ff      <= cur_slot_in;
         remaining_ff     <= remaining_in;
         start_pending_ff <= start_pending_in;
         is_playing_ff    <= is_playing_in;
         tone_enable_ff   <= tone_enable_in;
         tone_reload_ff   <= tone_reload_in;
         first_nz_ff      <= first_nz_in;
         last_slot_ff     <= last_slot_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff      <= status_in;
         rsp_tone_on_ff     <= tone_enable_in;
         rsp_tone_period_ff <= tone_reload_in;
         rsp_playing_ff     <= is_playing_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_tone_on     = rsp_tone_on_ff;
   assign rsp_tone_period = rsp_tone_period_ff;
   assign rsp_playing     = rsp_playing_ff;

`ifndef SYNTHESIS
   // An armed tune has not started, so it cannot be playing yet.
   a_pending_not_playing: assert property (@(posedge clock) disable iff (reset)
      !(start_pending_ff && is_playing_ff))
      else $error("armed tune reported as playing");

   // The current tune and slot always lie inside the table.
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cur_tune_ff} < TUNE_LIMIT) && (cur_slot_ff <= LAST_SLOT))
      else $error("playback cursor outside the note table");

   // A busy status leaves the requested tune playing.
   a_busy_means_playing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_BUSY)) |-> rsp_playing)
      else $error("busy status while no tune is playing");

   // A transaction that leaves the input register produces a response.
   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed transaction produced no response");
`endif

endmodule
